// File: rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Widths and sequencer state codes for the triangle tangent space block.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int W_INDEX = 24;
    localparam int W_POS   = 24;
    localparam int W_UV    = 16;
    localparam int W_UNIT  = 16;
    localparam int W_EDGE  = 25;
    localparam int W_DUV   = 17;
    localparam int W_VEC   = 44;
    localparam int W_MAG   = 43;
    localparam int W_NORM  = 30;
    localparam int W_SUM   = 62;
    localparam int W_LEN   = 31;
    localparam int W_OP    = 32;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PREP = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_NORM = 8'b0000_1000,
        S_SQ   = 8'b0001_0000,
        S_SQRT = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

endpackage

// File: rtl/triangle_tangent_space.sv
// ----------------------------------------------------------------------------
// triangle_tangent_space
// Corners are taken while the block is idle, one per accepted handshake; the
// third corner starts the work on the triangle. When the UV determinant is zero
// the normalising, root and divide steps are skipped; otherwise the work is done by one shared
// 32x32 multiplier, a one-bit-a-cycle normalising shifter, a 31-step square
// root and 16-step dividers.
// No new corner is taken until all three result items have been accepted.
// Reset: synchronous, active low; clears the sequencer, corner count and result item count.
// ----------------------------------------------------------------------------
module triangle_tangent_space (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic        [tts_pkg::W_INDEX-1:0]    i_vertex_index,
    input  logic signed [tts_pkg::W_POS-1:0]      i_pos_x,
    input  logic signed [tts_pkg::W_POS-1:0]      i_pos_y,
    input  logic signed [tts_pkg::W_POS-1:0]      i_pos_z,
    input  logic signed [tts_pkg::W_UV-1:0]       i_tex_u,
    input  logic signed [tts_pkg::W_UV-1:0]       i_tex_v,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic        [tts_pkg::W_INDEX-1:0]    o_target_index,
    output logic signed [tts_pkg::W_UNIT-1:0]     o_tan_x,
    output logic signed [tts_pkg::W_UNIT-1:0]     o_tan_y,
    output logic signed [tts_pkg::W_UNIT-1:0]     o_tan_z,
    output logic signed [tts_pkg::W_UNIT-1:0]     o_bitan_x,
    output logic signed [tts_pkg::W_UNIT-1:0]     o_bitan_y,
    output logic signed [tts_pkg::W_UNIT-1:0]     o_bitan_z,
    output logic                                  o_degenerate,
    output logic                                  o_last_of_triangle
);
    import tts_pkg::*;

    t_state r_state, n_state;

    logic        [1:0]          r_count;
    logic        [W_INDEX-1:0]  r_idx [3];
    logic signed [W_POS-1:0]    r_pos [3][3];
    logic signed [W_UV-1:0]     r_uv  [3][2];

    logic signed [W_EDGE-1:0]   r_e1 [3];
    logic signed [W_EDGE-1:0]   r_e2 [3];
    logic signed [W_DUV-1:0]    r_d1u, r_d1v, r_d2u, r_d2v;

    logic        [3:0]          r_step;
    logic signed [63:0]         r_prod;
    logic signed [W_VEC-1:0]    r_acc;
    logic                       r_det_neg, r_det_zero;
    logic signed [W_VEC-1:0]    r_t [3];
    logic signed [W_VEC-1:0]    r_b [3];

    logic                       r_vec;
    logic        [W_MAG-1:0]    r_m [3];
    logic                       r_neg [3];
    logic        [W_SUM-1:0]    r_sum;
    logic        [W_SUM-1:0]    r_root;
    logic        [4:0]          r_cnt;
    logic        [1:0]          r_comp;
    logic        [31:0]         r_drem;
    logic        [15:0]         r_nlo;
    logic        [15:0]         r_q;

    logic signed [W_UNIT-1:0]   r_tq [3];
    logic signed [W_UNIT-1:0]   r_bq [3];
    logic                       r_deg;
    logic        [1:0]          r_k;

    logic                       w_in_acc, w_out_acc;
    logic signed [W_OP-1:0]     w_ma, w_mb;
    logic signed [63:0]         w_mul;
    logic        [2:0]          w_pair;
    logic        [1:0]          w_i;
    logic        [1:0]          w_mi;
    logic        [W_MAG-1:0]    w_msel;
    logic        [W_MAG-1:0]    w_or;
    logic        [3:0]          w_j;
    logic signed [W_VEC-1:0]    w_p44, w_diff, w_fin;
    logic        [W_SUM-1:0]    w_bit, w_trial;
    logic        [45:0]         w_num;
    logic        [32:0]         w_dtrial, w_dden;
    logic signed [W_UNIT-1:0]   w_qs;

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = (r_state == S_OUT);
    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;

    assign w_pair = r_step[3:1];
    assign w_mi   = (r_state == S_SQ) ? r_step[1:0] : r_comp;
    assign w_msel = r_m[w_mi];
    assign w_or   = r_m[0] | r_m[1] | r_m[2];
    assign w_j    = r_step - 4'd1;

    always_comb begin
        w_i  = 2'd0;
        w_ma = '0;
        w_mb = '0;
        if (r_state == S_SQ) begin
            w_ma = W_OP'({2'b00, w_msel[W_NORM-1:0]});
            w_mb = w_ma;
        end else begin
            priority if (w_pair == 3'd0) begin
                w_ma = r_step[0] ? W_OP'(r_d2u) : W_OP'(r_d1u);
                w_mb = r_step[0] ? W_OP'(r_d1v) : W_OP'(r_d2v);
            end else if (w_pair <= 3'd3) begin
                w_i  = 2'(w_pair - 3'd1);
                w_ma = r_step[0] ? W_OP'(r_d1v) : W_OP'(r_d2v);
                w_mb = r_step[0] ? W_OP'(r_e2[w_i]) : W_OP'(r_e1[w_i]);
            end else begin
                w_i  = 2'(w_pair - 3'd4);
                w_ma = r_step[0] ? W_OP'(r_d2u) : W_OP'(r_d1u);
                w_mb = r_step[0] ? W_OP'(r_e1[w_i]) : W_OP'(r_e2[w_i]);
            end
        end
    end

    assign w_mul  = w_ma * w_mb;
    assign w_p44  = r_prod[W_VEC-1:0];
    assign w_diff = r_acc - w_p44;
    assign w_fin  = r_det_neg ? -w_diff : w_diff;

    assign w_bit   = W_SUM'(1) << {r_cnt, 1'b0};
    assign w_trial = r_root + w_bit;

    assign w_num    = {1'b0, w_msel[W_NORM-1:0], 15'd0} + 46'(r_root[W_LEN-1:0]);
    assign w_dden   = {1'b0, r_root[W_LEN-1:0], 1'b0};
    assign w_dtrial = {r_drem, r_nlo[15]};
    assign w_qs     = r_neg[r_comp] ? -$signed(r_q) : $signed(r_q);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc && r_count == 2'd2) n_state = S_PREP;
            S_PREP: n_state = S_MUL;
            S_MUL:  if (r_step == 4'd14) n_state = r_det_zero ? S_OUT : S_NORM;
            S_NORM: begin
                if (w_or == '0) n_state = S_OUT;
                else if (w_or[W_MAG-1:W_NORM] == '0 && w_or[W_NORM-1]) n_state = S_SQ;
            end
            S_SQ:   if (r_step == 4'd3) n_state = S_SQRT;
            S_SQRT: if (r_cnt == 5'd0) n_state = S_DIV;
            S_DIV:  if (r_cnt == 5'd17 && r_comp == 2'd2) n_state = r_vec ? S_OUT : S_NORM;
            S_OUT:  if (w_out_acc && r_k == 2'd2) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= 2'd0;
            r_k     <= 2'd0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_idx[r_count]    <= i_vertex_index;
                        r_pos[r_count][0] <= i_pos_x;
                        r_pos[r_count][1] <= i_pos_y;
                        r_pos[r_count][2] <= i_pos_z;
                        r_uv[r_count][0]  <= i_tex_u;
                        r_uv[r_count][1]  <= i_tex_v;
                        r_count <= (r_count == 2'd2) ? 2'd0 : r_count + 2'd1;
                    end
                end
                S_PREP: begin
                    for (int i = 0; i < 3; i++) begin
                        r_e1[i] <= W_EDGE'(r_pos[1][i]) - W_EDGE'(r_pos[0][i]);
                        r_e2[i] <= W_EDGE'(r_pos[2][i]) - W_EDGE'(r_pos[0][i]);
                    end
                    r_d1u     <= W_DUV'(r_uv[1][0]) - W_DUV'(r_uv[0][0]);
                    r_d1v     <= W_DUV'(r_uv[1][1]) - W_DUV'(r_uv[0][1]);
                    r_d2u     <= W_DUV'(r_uv[2][0]) - W_DUV'(r_uv[0][0]);
                    r_d2v     <= W_DUV'(r_uv[2][1]) - W_DUV'(r_uv[0][1]);
                    r_step    <= 4'd0;
                    r_deg     <= 1'b0;
                    r_vec     <= 1'b0;
                    r_det_neg <= 1'b0;
                end
                S_MUL: begin
                    if (r_step != 4'd14) r_prod <= w_mul;
                    if (r_step != 4'd0) begin
                        if (!w_j[0]) begin
                            r_acc <= w_p44;
                        end else if (w_j[3:1] == 3'd0) begin
                            r_det_neg  <= w_diff[W_VEC-1];
                            r_det_zero <= (w_diff == '0);
                        end else if (w_j[3:1] <= 3'd3) begin
                            r_t[2'(w_j[3:1] - 3'd1)] <= w_fin;
                        end else begin
                            r_b[2'(w_j[3:1] - 3'd4)] <= w_fin;
                        end
                    end
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd14) begin
                        r_deg <= r_det_zero;
                        for (int i = 0; i < 3; i++) begin
                            r_neg[i] <= r_t[i][W_VEC-1];
                            r_m[i]   <= W_MAG'(r_t[i][W_VEC-1] ? -r_t[i] : r_t[i]);
                        end
                    end
                end
                S_NORM: begin
                    r_step <= 4'd0;
                    r_sum  <= '0;
                    if (w_or == '0) begin
                        r_deg <= 1'b1;
                    end else if (w_or[W_MAG-1:W_NORM] != '0) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else if (!w_or[W_NORM-1]) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                    end
                end
                S_SQ: begin
                    if (r_step != 4'd3) r_prod <= w_mul;
                    if (r_step != 4'd0) r_sum <= r_sum + r_prod[W_SUM-1:0];
                    r_step <= r_step + 4'd1;
                    r_root <= '0;
                    r_cnt  <= 5'd30;
                end
                S_SQRT: begin
                    if (r_sum >= w_trial) begin
                        r_sum  <= r_sum - w_trial;
                        r_root <= (r_root >> 1) + w_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_cnt  <= r_cnt - 5'd1;
                    r_comp <= 2'd0;
                end
                S_DIV: begin
                    if (r_cnt == 5'd0) begin
                        r_drem <= 32'(w_num[45:16]);
                        r_nlo  <= w_num[15:0];
                        r_q    <= '0;
                        r_cnt  <= r_cnt + 5'd1;
                    end else if (r_cnt != 5'd17) begin
                        if (w_dtrial >= w_dden) begin
                            r_drem <= 32'(w_dtrial - w_dden);
                            r_q    <= {r_q[14:0], 1'b1};
                        end else begin
                            r_drem <= w_dtrial[31:0];
                            r_q    <= {r_q[14:0], 1'b0};
                        end
                        r_nlo <= r_nlo << 1;
                        r_cnt <= r_cnt + 5'd1;
                    end else begin
                        if (r_vec) r_bq[r_comp] <= w_qs;
                        else       r_tq[r_comp] <= w_qs;
                        r_cnt <= 5'd0;
                        if (r_comp == 2'd2) begin
                            r_vec <= 1'b1;
                            for (int i = 0; i < 3; i++) begin
                                r_neg[i] <= r_b[i][W_VEC-1];
                                r_m[i]   <= W_MAG'(r_b[i][W_VEC-1] ? -r_b[i] : r_b[i]);
                            end
                        end else begin
                            r_comp <= r_comp + 2'd1;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_acc) r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                end
                default: ;
            endcase
        end
    end

    assign o_target_index     = r_idx[r_k];
    assign o_tan_x            = r_deg ? '0 : r_tq[0];
    assign o_tan_y            = r_deg ? '0 : r_tq[1];
    assign o_tan_z            = r_deg ? '0 : r_tq[2];
    assign o_bitan_x          = r_deg ? '0 : r_bq[0];
    assign o_bitan_y          = r_deg ? '0 : r_bq[1];
    assign o_bitan_z          = r_deg ? '0 : r_bq[2];
    assign o_degenerate       = r_deg;
    assign o_last_of_triangle = (r_k == 2'd2);

endmodule

// File: rtl/tts_checker.sv
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks on the triangle tangent space block.
// ----------------------------------------------------------------------------
module tts_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_ready,
    input logic                                  o_valid,
    input logic                                  i_ready,
    input logic signed [tts_pkg::W_UNIT-1:0]     o_tan_x,
    input logic signed [tts_pkg::W_UNIT-1:0]     o_tan_y,
    input logic signed [tts_pkg::W_UNIT-1:0]     o_tan_z,
    input logic signed [tts_pkg::W_UNIT-1:0]     o_bitan_x,
    input logic signed [tts_pkg::W_UNIT-1:0]     o_bitan_y,
    input logic signed [tts_pkg::W_UNIT-1:0]     o_bitan_z,
    input logic                                  o_degenerate,
    input logic                                  o_last_of_triangle
);

    // no new corner while results are pending
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input ready while results pending");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result item dropped");

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_tan_x == 0 && o_tan_y == 0 && o_tan_z == 0
            && o_bitan_x == 0 && o_bitan_y == 0 && o_bitan_z == 0)
        else $error("degenerate item with non-zero vectors");

    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last_of_triangle |=> !o_valid && o_ready)
        else $error("results continue after last item");

endmodule

bind triangle_tangent_space tts_checker u_tts_checker (.*);

// File: sim/tb_triangle_tangent_space.sv
// ----------------------------------------------------------------------------
// tb_triangle_tangent_space
// Streams triangle corners through the tangent space unit under varying
// sender and receiver idling, predicts the three result items of each
// triangle in fixed point and checks every field of every result item.
// ----------------------------------------------------------------------------
module tb_triangle_tangent_space;
    import tts_pkg::*;

    typedef struct {
        logic [W_INDEX-1:0] idx;
        logic signed [W_UNIT-1:0] t [3];
        logic signed [W_UNIT-1:0] b [3];
        logic deg;
        logic last;
    } frame_t;

    class frame_board;
        logic [W_INDEX-1:0] hidx [2];
        longint hpos [6];
        longint huv [4];
        int corner;
        frame_t pending [$];
        int errors;
        int checked;
        int degen_seen;

        function void clear();
            corner = 0;
            errors = 0;
            checked = 0;
            degen_seen = 0;
            foreach (hidx[i]) hidx[i] = '0;
            foreach (hpos[i]) hpos[i] = 0;
            foreach (huv[i]) huv[i] = 0;
        endfunction

        function longint unsigned root(longint unsigned s);
            longint unsigned r, bt;
            r = 0;
            bt = 64'd1 << 62;
            while (bt > s) bt = bt >> 2;
            while (bt != 0) begin
                if (s >= r + bt) begin
                    s = s - (r + bt);
                    r = (r >> 1) + bt;
                end else begin
                    r = r >> 1;
                end
                bt = bt >> 2;
            end
            return r;
        endfunction

        function bit unit_vec(longint v [3], output logic signed [W_UNIT-1:0] o [3]);
            longint unsigned m [3];
            longint unsigned mx, s, len, q;
            int rs, ls;
            mx = 0;
            s = 0;
            rs = 0;
            ls = 0;
            for (int i = 0; i < 3; i++) begin
                m[i] = v[i] < 0 ? -v[i] : v[i];
                mx |= m[i];
                o[i] = '0;
            end
            if (mx == 0) return 0;
            while ((mx >> rs) >= (64'd1 << 30)) rs++;
            while ((mx << ls) < (64'd1 << 29)) ls++;
            for (int i = 0; i < 3; i++) begin
                m[i] = (m[i] >> rs) << ls;
                s += m[i] * m[i];
            end
            len = root(s);
            for (int i = 0; i < 3; i++) begin
                q = (m[i] * 32768 + len) / (2 * len);
                o[i] = W_UNIT'(v[i] < 0 ? -q : q);
            end
            return 1;
        endfunction

        function void note_corner(logic [W_INDEX-1:0] idx, longint p [3], longint uv [2]);
            longint e1 [3], e2 [3], tv [3], bv [3];
            longint d1u, d1v, d2u, d2v, det;
            logic signed [W_UNIT-1:0] tq [3], bq [3];
            logic [W_INDEX-1:0] tgt [3];
            bit deg;
            frame_t f;
            if (corner < 2) begin
                hidx[corner] = idx;
                for (int i = 0; i < 3; i++) hpos[corner*3+i] = p[i];
                huv[corner*2] = uv[0];
                huv[corner*2+1] = uv[1];
                corner++;
                return;
            end
            corner = 0;
            for (int i = 0; i < 3; i++) begin
                e1[i] = hpos[3+i] - hpos[i];
                e2[i] = p[i] - hpos[i];
            end
            d1u = huv[2] - huv[0];
            d1v = huv[3] - huv[1];
            d2u = uv[0] - huv[0];
            d2v = uv[1] - huv[1];
            det = d1u * d2v - d2u * d1v;
            for (int i = 0; i < 3; i++) begin
                tv[i] = d2v * e1[i] - d1v * e2[i];
                bv[i] = d1u * e2[i] - d2u * e1[i];
                if (det < 0) begin
                    tv[i] = -tv[i];
                    bv[i] = -bv[i];
                end
            end
            deg = (det == 0);
            if (!deg) deg = !unit_vec(tv, tq);
            if (!deg) deg = !unit_vec(bv, bq);
            if (deg) degen_seen++;
            tgt[0] = hidx[0];
            tgt[1] = hidx[1];
            tgt[2] = idx;
            for (int k = 0; k < 3; k++) begin
                f.idx = tgt[k];
                for (int i = 0; i < 3; i++) begin
                    f.t[i] = deg ? '0 : tq[i];
                    f.b[i] = deg ? '0 : bq[i];
                end
                f.deg = deg;
                f.last = (k == 2);
                pending.insert(pending.size(), f);
            end
        endfunction

        function void check_frame(frame_t a);
            frame_t e;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t unexpected result item index %h", $time, a.idx);
                return;
            end
            e = pending.pop_front();
            if (e.idx !== a.idx || e.deg !== a.deg || e.last !== a.last) begin
                errors++;
                $display("%0t idx/deg/last exp %h %b %b got %h %b %b", $time,
                         e.idx, e.deg, e.last, a.idx, a.deg, a.last);
            end
            for (int i = 0; i < 3; i++) begin
                if (e.t[i] !== a.t[i] || e.b[i] !== a.b[i]) begin
                    errors++;
                    $display("%0t comp %0d tan exp %0d got %0d bitan exp %0d got %0d",
                             $time, i, e.t[i], a.t[i], e.b[i], a.b[i]);
                end
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    logic [W_INDEX-1:0] i_vertex_index, o_target_index;
    logic signed [W_POS-1:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [W_UV-1:0] i_tex_u, i_tex_v;
    logic signed [W_UNIT-1:0] o_tan_x, o_tan_y, o_tan_z, o_bitan_x, o_bitan_y, o_bitan_z;
    logic o_degenerate, o_last_of_triangle;

    frame_board board;
    int send_idle_pct;
    int recv_stall_pct;

    triangle_tangent_space DUT (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // result side: checking at the rising edge, stall pattern at the falling edge
    always @(posedge i_clk) begin
        frame_t a;
        if (i_rst_n && o_valid && i_ready) begin
            a.idx = o_target_index;
            a.t[0] = o_tan_x;
            a.t[1] = o_tan_y;
            a.t[2] = o_tan_z;
            a.b[0] = o_bitan_x;
            a.b[1] = o_bitan_y;
            a.b[2] = o_bitan_z;
            a.deg = o_degenerate;
            a.last = o_last_of_triangle;
            board.check_frame(a);
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // valid stays high from one item to the next unless the sender idles
    task automatic send_corner(logic [W_INDEX-1:0] idx, logic [W_POS-1:0] px,
                               logic [W_POS-1:0] py, logic [W_POS-1:0] pz,
                               logic [W_UV-1:0] tu, logic [W_UV-1:0] tv);
        longint p [3], uv [2];
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_vertex_index <= idx;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        i_tex_u <= tu;
        i_tex_v <= tv;
        do @(posedge i_clk); while (!o_ready);
        p[0] = $signed(px);
        p[1] = $signed(py);
        p[2] = $signed(pz);
        uv[0] = $signed(tu);
        uv[1] = $signed(tv);
        board.note_corner(idx, p, uv);
        @(negedge i_clk);
    endtask

    function automatic logic [W_POS-1:0] rand_pos(int mode);
        case (mode)
            0: return W_POS'($urandom);
            1: return W_POS'($urandom_range(2047) - 1024);
            default: return ($urandom_range(1) ? 24'h800000 : 24'h7fffff);
        endcase
    endfunction

    task automatic send_random_triangle();
        int mode;
        logic [W_UV-1:0] u0, v0;
        mode = $urandom_range(9) < 6 ? 0 : ($urandom_range(3) == 0 ? 2 : 1);
        u0 = W_UV'($urandom);
        v0 = W_UV'($urandom);
        for (int c = 0; c < 3; c++) begin
            logic [W_UV-1:0] tu, tv;
            tu = W_UV'($urandom);
            tv = W_UV'($urandom);
            // occasionally repeat UVs so the determinant vanishes
            if ($urandom_range(9) == 0) begin
                tu = u0;
                tv = v0;
            end
            if (c == 0) begin
                tu = u0;
                tv = v0;
            end
            send_corner(W_INDEX'($urandom), rand_pos(mode), rand_pos(mode), rand_pos(mode),
                        tu, tv);
        end
    endtask

    task automatic drain();
        i_valid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    initial begin
        board = new();
        board.clear();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        i_vertex_index = 0;
        i_pos_x = 0;
        i_pos_y = 0;
        i_pos_z = 0;
        i_tex_u = 0;
        i_tex_v = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: unit right triangle, extremes, zero determinant, zero edges
        send_corner(0, 0, 0, 0, 0, 0);
        send_corner(1, 24'h010000, 0, 0, 16'h1000, 0);
        send_corner(24'hffffff, 0, 24'h010000, 0, 0, 16'h1000);
        send_corner(5, 24'h800000, 24'h800000, 24'h800000, 16'h8000, 16'h8000);
        send_corner(6, 24'h7fffff, 24'h7fffff, 24'h7fffff, 16'h7fff, 16'h8000);
        send_corner(7, 24'h800000, 24'h7fffff, 24'h000001, 16'h8000, 16'h7fff);
        send_corner(8, 24'h123456, 24'h0, 24'h0, 16'h0100, 16'h0100);
        send_corner(9, 24'h223456, 24'h1, 24'h0, 16'h0100, 16'h0100);
        send_corner(10, 24'h323456, 24'h0, 24'h3, 16'h0200, 16'h0200);
        send_corner(11, 24'h000100, 24'h000100, 24'h000100, 0, 0);
        send_corner(12, 24'h000100, 24'h000100, 24'h000100, 16'h1000, 0);
        send_corner(13, 24'h000100, 24'h000100, 24'h000100, 0, 16'h1000);
        send_corner(14, 24'h7fffff, 24'h800000, 24'h7fffff, 16'h7fff, 16'h7fff);
        send_corner(15, 24'h800000, 24'h7fffff, 24'h800000, 16'h8000, 16'h7fff);
        send_corner(16, 24'h7fffff, 24'h7fffff, 24'h800000, 16'h7fff, 16'h8000);
        send_corner(17, 0, 0, 0, 16'h0000, 16'h0000);
        send_corner(18, 24'hfffffe, 0, 0, 16'hf000, 16'h0001);
        send_corner(19, 0, 24'h000002, 0, 16'h0001, 16'hf000);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 88 : 36) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 88 : 36) : 0;
            for (int n = 0; n < 11; n++) begin
                send_random_triangle();
                if (n == 5) begin
                    i_valid <= 0;
                    while (board.pending.size() != 0) @(negedge i_clk);
                end
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        $display("covered %0d result items, %0d degenerate triangles, four idling phases",
                 board.checked, board.degen_seen);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end
endmodule
